### rtl/wpe_pkg.sv
// Package for the one-wire LED pulse encoder: shared types, register indexes,
// pulse step positions and default settings. Depends on nothing.
package wpe_pkg;

    localparam int unsigned COLOR_W    = 8;
    localparam int unsigned PIXEL_W    = 3 * COLOR_W;
    localparam int unsigned BIT_TIME_W = 10;
    localparam int unsigned LATCH_W    = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned STEP_W     = 5;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [BIT_TIME_W-1:0] ZERO_HIGH_RST = 10'd7;
    localparam logic [BIT_TIME_W-1:0] ZERO_LOW_RST  = 10'd34;
    localparam logic [BIT_TIME_W-1:0] ONE_HIGH_RST  = 10'd32;
    localparam logic [BIT_TIME_W-1:0] ONE_LOW_RST   = 10'd1;
    localparam logic [LATCH_W-1:0]    LATCH_RST     = 16'd3600;

    // Position of a pulse within one pixel's sequence.
    localparam logic [STEP_W-1:0] STEP_OPEN      = 5'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST_BIT = 5'd1;
    localparam logic [STEP_W-1:0] STEP_LAST_BIT  = 5'd24;
    localparam logic [STEP_W-1:0] STEP_CLOSE     = 5'd25;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_HIGH  = 3'd0,
        REG_ZERO_LOW   = 3'd1,
        REG_ONE_HIGH   = 3'd2,
        REG_ONE_LOW    = 3'd3,
        REG_LATCH      = 3'd4,
        REG_OUT_ENABLE = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [BIT_TIME_W-1:0] zero_high;
        logic [BIT_TIME_W-1:0] zero_low;
        logic [BIT_TIME_W-1:0] one_high;
        logic [BIT_TIME_W-1:0] one_low;
        logic [LATCH_W-1:0]    latch;
        logic                  out_enable;
    } cfg_t;

    // One classified pixel as it travels from the front to the back.
    typedef struct packed {
        logic [PIXEL_W-1:0] colors;      // green, red, blue; MSB sent first
        logic               open_latch;  // latch pulse before the bits
        logic               close_latch; // latch pulse after the bits
    } job_t;

endpackage

### rtl/wpe_if.sv
// Channel interfaces of the pulse encoder: pixel input, pulse output and
// register write port. Depends on wpe_pkg.
interface wpe_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [wpe_pkg::COLOR_W-1:0]    green;
    logic [wpe_pkg::COLOR_W-1:0]    red;
    logic [wpe_pkg::COLOR_W-1:0]    blue;
    logic                           last_pixel;

    modport source (output valid, green, red, blue, last_pixel, input ready);
    modport sink (input valid, green, red, blue, last_pixel, output ready);
endinterface

interface wpe_pulse_if;
    logic                           valid;
    logic                           ready;
    logic [wpe_pkg::BIT_TIME_W-1:0] high_cycles;
    logic [wpe_pkg::LATCH_W-1:0]    low_cycles;
    logic                           is_latch;
    logic                           last;

    modport source (output valid, high_cycles, low_cycles, is_latch, last, input ready);
    modport sink (input valid, high_cycles, low_cycles, is_latch, last, output ready);
endinterface

interface wpe_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [wpe_pkg::CFG_IDX_W-1:0]  index;
    logic [wpe_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/wpe_front.sv
// Front end of the pulse encoder: accepts pixels, drops them while output is
// disabled, and tracks the open frame. Depends on wpe_pkg.
module wpe_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        out_enable,
    input  logic                        pix_valid,
    output logic                        pix_ready,
    input  logic [wpe_pkg::PIXEL_W-1:0] pix_colors,
    input  logic                        pix_last,
    output logic                        job_valid,
    input  logic                        job_ready,
    output wpe_pkg::job_t               job
);

    logic frame_open_reg;
    logic frame_open_next;
    logic accept;

    // While disabled every pixel is taken and thrown away.
    assign pix_ready = job_ready || !out_enable;
    assign accept    = pix_valid && pix_ready;
    assign job_valid = pix_valid && out_enable;

    assign job.colors      = pix_colors;
    assign job.open_latch  = !frame_open_reg;
    assign job.close_latch = pix_last;

    always_comb
    begin
        frame_open_next = frame_open_reg;
        if (accept && out_enable)
        begin
            frame_open_next = !pix_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

### rtl/wpe_queue.sv
// Short job queue between front and back of the pulse encoder.
// Depends on wpe_pkg.
module wpe_queue #(
    parameter int unsigned DEPTH = wpe_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  wpe_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output wpe_pkg::job_t pop_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    wpe_pkg::job_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### rtl/wpe_back.sv
// Back end of the pulse encoder: turns a queued job into registered latch
// and bit pulses, one per cycle while not stalled. Depends on wpe_pkg.
module wpe_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wpe_pkg::cfg_t                   cfg,
    input  logic                            job_valid,
    output logic                            job_ready,
    input  wpe_pkg::job_t                   job,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [wpe_pkg::BIT_TIME_W-1:0]  out_high,
    output logic [wpe_pkg::LATCH_W-1:0]     out_low,
    output logic                            out_is_latch,
    output logic                            out_last
);

    logic                           busy_reg;
    logic                           busy_next;
    logic [wpe_pkg::STEP_W-1:0]     step_reg;
    logic [wpe_pkg::STEP_W-1:0]     step_next;
    logic [wpe_pkg::PIXEL_W-1:0]    bits_reg;
    logic [wpe_pkg::PIXEL_W-1:0]    bits_next;
    logic                           close_reg;
    logic                           close_next;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [wpe_pkg::BIT_TIME_W-1:0] out_high_reg;
    logic [wpe_pkg::LATCH_W-1:0]    out_low_reg;
    logic                           out_is_latch_reg;
    logic                           out_last_reg;

    logic                           advance;
    logic                           produce;
    logic                           cur_latch;
    logic                           cur_last;
    logic [wpe_pkg::BIT_TIME_W-1:0] cur_high;
    logic [wpe_pkg::LATCH_W-1:0]    cur_low;

    assign advance   = !out_valid_reg || out_ready;
    assign produce   = busy_reg && advance;
    assign job_ready = !busy_reg || (produce && cur_last);

    // Pulse at the current step.
    always_comb
    begin
        cur_latch = (step_reg == wpe_pkg::STEP_OPEN) || (step_reg == wpe_pkg::STEP_CLOSE);
        cur_last  = (step_reg == wpe_pkg::STEP_CLOSE) ||
                    ((step_reg == wpe_pkg::STEP_LAST_BIT) && !close_reg);
        if (cur_latch)
        begin
            cur_high = '0;
            cur_low  = cfg.latch;
        end
        else if (bits_reg[wpe_pkg::PIXEL_W-1])
        begin
            cur_high = cfg.one_high;
            cur_low  = wpe_pkg::LATCH_W'(cfg.one_low);
        end
        else
        begin
            cur_high = cfg.zero_high;
            cur_low  = wpe_pkg::LATCH_W'(cfg.zero_low);
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        bits_next  = bits_reg;
        close_next = close_reg;
        if (job_valid && job_ready)
        begin
            busy_next  = 1'b1;
            step_next  = job.open_latch ? wpe_pkg::STEP_OPEN : wpe_pkg::STEP_FIRST_BIT;
            bits_next  = job.colors;
            close_next = job.close_latch;
        end
        else if (produce && cur_last)
        begin
            busy_next = 1'b0;
        end
        else if (produce)
        begin
            step_next = step_reg + 1'b1;
            if (!cur_latch)
            begin
                bits_next = {bits_reg[wpe_pkg::PIXEL_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = produce;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        bits_reg  <= bits_next;
        close_reg <= close_next;
        if (produce)
        begin
            out_high_reg     <= cur_high;
            out_low_reg      <= cur_low;
            out_is_latch_reg <= cur_latch;
            out_last_reg     <= cur_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_high     = out_high_reg;
    assign out_low      = out_low_reg;
    assign out_is_latch = out_is_latch_reg;
    assign out_last     = out_last_reg;

endmodule

### rtl/ws2812_pulse_encoder_unit.sv
// Top level of the one-wire LED pulse encoder: register file, front end,
// job queue and pulse back end. Depends on wpe_pkg, wpe_if and the wpe_ modules.
//
//   Channel | Direction | Payload                                    | Transaction
//   --------+-----------+--------------------------------------------+----------------------
//   pixel   | in        | green, red, blue, last_pixel               | one pixel
//   pulse   | out       | high_cycles, low_cycles, is_latch, last    | one pulse descriptor
//   cfg     | in        | index, data                                | one register write
//
// A pixel becomes 24 bit pulses, plus a latch pulse in front when no frame is open
// and one behind when last_pixel is set. The back end sends one pulse per cycle
// while the pulse port is not stalled, with no gap between queued pixels.
// Reset (rst_n, asynchronous) empties the queue and the output register, closes
// the frame and loads the default timings with output disabled. A pulse stall holds
// the output register, the queue fills and the pixel port stalls in turn.
module ws2812_pulse_encoder_unit #(
    parameter int unsigned QUEUE_DEPTH = wpe_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    wpe_pixel_if.sink         pixel,
    wpe_pulse_if.source       pulse,
    wpe_cfg_if.sink           cfg
);

    // Configuration registers. Writes are always taken; an index past the
    // register list is ignored. The data word is cut to each register's width.
    // While output is disabled, the front end takes pixels and drops them.
    wpe_pkg::cfg_t cfg_reg;
    wpe_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (wpe_pkg::cfg_index_t'(cfg.index))
                wpe_pkg::REG_ZERO_HIGH:  cfg_next.zero_high  = cfg.data[wpe_pkg::BIT_TIME_W-1:0];
                wpe_pkg::REG_ZERO_LOW:   cfg_next.zero_low   = cfg.data[wpe_pkg::BIT_TIME_W-1:0];
                wpe_pkg::REG_ONE_HIGH:   cfg_next.one_high   = cfg.data[wpe_pkg::BIT_TIME_W-1:0];
                wpe_pkg::REG_ONE_LOW:    cfg_next.one_low    = cfg.data[wpe_pkg::BIT_TIME_W-1:0];
                wpe_pkg::REG_LATCH:      cfg_next.latch      = cfg.data[wpe_pkg::LATCH_W-1:0];
                wpe_pkg::REG_OUT_ENABLE: cfg_next.out_enable = cfg.data[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_high  <= wpe_pkg::ZERO_HIGH_RST;
            cfg_reg.zero_low   <= wpe_pkg::ZERO_LOW_RST;
            cfg_reg.one_high   <= wpe_pkg::ONE_HIGH_RST;
            cfg_reg.one_low    <= wpe_pkg::ONE_LOW_RST;
            cfg_reg.latch      <= wpe_pkg::LATCH_RST;
            cfg_reg.out_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end to queue.
    logic          front_valid;
    logic          front_ready;
    wpe_pkg::job_t front_job;

    // Queue to back end.
    logic          back_valid;
    logic          back_ready;
    wpe_pkg::job_t back_job;

    wpe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .out_enable (cfg_reg.out_enable),
        .pix_valid  (pixel.valid),
        .pix_ready  (pixel.ready),
        .pix_colors ({pixel.green, pixel.red, pixel.blue}),
        .pix_last   (pixel.last_pixel),
        .job_valid  (front_valid),
        .job_ready  (front_ready),
        .job        (front_job)
    );

    wpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job)
    );

    wpe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job_valid    (back_valid),
        .job_ready    (back_ready),
        .job          (back_job),
        .out_valid    (pulse.valid),
        .out_ready    (pulse.ready),
        .out_high     (pulse.high_cycles),
        .out_low      (pulse.low_cycles),
        .out_is_latch (pulse.is_latch),
        .out_last     (pulse.last)
    );

endmodule
